FILE: rtl/quadratic_probe_hash_table_defines.svh
// Assertion macros used by the hash table top level.
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

// Checked property that is switched off while reset is asserted.
`define QPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property that also holds during reset.
`define QPHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/qpht_pkg.sv
`timescale 1ns / 1ps

package qpht_pkg;

  localparam int KEY_W          = 64;
  localparam int PORT_PAYLOAD_W = 32;
  localparam int PORT_SLOT_W    = 10;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NULL_KEY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT_CLR,
    S_IDLE,
    S_OP_CLR,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_RESP
  } state_e;

  // Which result the datapath latches when res_load is raised.
  typedef enum logic [2:0] {
    RES_OK,
    RES_NULL,
    RES_FULL,
    RES_NOT_FOUND,
    RES_HIT,
    RES_INS
  } res_sel_e;

  typedef struct packed {
    logic     load;       // capture the input transfer
    logic     sweep;      // clear the valid bit at the current address
    logic     advance;    // step to the next triangular probe
    logic     mem_write;  // write keys and payload at the probed slot
    logic     res_load;   // latch a pending result
    res_sel_e res_sel;
    logic     out_load;   // move the pending result to the output register
  } cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_probe;     // lookup or insert offered
    logic in_key_zero;
    logic op_insert;    // captured op is an insert
    logic empty;
    logic hit;
    logic last_probe;
    logic sweep_last;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/qpht_datapath.sv
`timescale 1ns / 1ps

module qpht_datapath #(
  parameter int LOG2_SLOTS   = 10,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qpht_pkg::cmd_t                      cmd_i,
  output qpht_pkg::sts_t                      sts_o,
  input  logic [1:0]                          op_i,
  input  logic signed [qpht_pkg::KEY_W-1:0]   class_tag_i,
  input  logic [qpht_pkg::KEY_W-1:0]          field_key_i,
  input  logic [qpht_pkg::PORT_PAYLOAD_W-1:0] payload_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [qpht_pkg::PORT_PAYLOAD_W-1:0] payload_out_o,
  output logic [qpht_pkg::PORT_SLOT_W-1:0]    slot_index_o
);
  import qpht_pkg::*;

  localparam int DEPTH = 1 << LOG2_SLOTS;

  logic                    val_mem_q [DEPTH];
  logic [KEY_W-1:0]        tag_mem_q [DEPTH];
  logic [KEY_W-1:0]        key_mem_q [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem_q [DEPTH];

  logic                    rd_valid_q;
  logic [KEY_W-1:0]        rd_tag_q, rd_key_q;
  logic [PAYLOAD_BITS-1:0] rd_pay_q;

  logic [LOG2_SLOTS-1:0]   pos_q, pos_d, i_q, i_d;
  logic [1:0]              op_q;
  logic [KEY_W-1:0]        tag_q, key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  logic [1:0]                res_status_q, res_status_d;
  logic [PORT_PAYLOAD_W-1:0] res_pay_q, res_pay_d;
  logic [PORT_SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic                      out_valid_q;
  logic [1:0]                out_status_q;
  logic [PORT_PAYLOAD_W-1:0] out_pay_q;
  logic [PORT_SLOT_W-1:0]    out_slot_q;

  logic [63:0]             pay_in_ext, pay_rd_ext;
  logic [15:0]             pos_ext;
  logic [LOG2_SLOTS-1:0]   home;

  assign home       = LOG2_SLOTS'(class_tag_i ^ field_key_i);
  assign pay_in_ext = 64'(payload_in_i);
  assign pay_rd_ext = 64'(rd_pay_q);
  assign pos_ext    = 16'(pos_q);

  always_comb begin
    pos_d = pos_q;
    i_d   = i_q;
    if (cmd_i.load) begin
      pos_d = (op_e'(op_i) == OP_CLEAR) ? '0 : home;
      i_d   = '0;
    end else if (cmd_i.sweep) begin
      pos_d = LOG2_SLOTS'(pos_q + 1'b1);
    end else if (cmd_i.advance) begin
      pos_d = LOG2_SLOTS'(pos_q + i_q + 1'b1);
      i_d   = LOG2_SLOTS'(i_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      i_q   <= '0;
    end else begin
      pos_q <= pos_d;
      i_q   <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      tag_q <= class_tag_i;
      key_q <= field_key_i;
      pay_q <= pay_in_ext[PAYLOAD_BITS-1:0];
    end
  end

  // Slot memory: one address a cycle, read data registered.
  always_ff @(posedge clk_i) begin
    rd_valid_q <= val_mem_q[pos_q];
    rd_tag_q   <= tag_mem_q[pos_q];
    rd_key_q   <= key_mem_q[pos_q];
    rd_pay_q   <= pay_mem_q[pos_q];
    if (cmd_i.sweep) begin
      val_mem_q[pos_q] <= 1'b0;
    end else if (cmd_i.mem_write) begin
      val_mem_q[pos_q] <= 1'b1;
      tag_mem_q[pos_q] <= tag_q;
      key_mem_q[pos_q] <= key_q;
      pay_mem_q[pos_q] <= pay_q;
    end
  end

  always_comb begin
    res_status_d = ST_OK;
    res_pay_d    = '0;
    res_slot_d   = '0;
    case (cmd_i.res_sel)
      RES_OK:        res_status_d = ST_OK;
      RES_NULL:      res_status_d = ST_NULL_KEY;
      RES_FULL:      res_status_d = ST_FULL;
      RES_NOT_FOUND: res_status_d = ST_NOT_FOUND;
      RES_HIT: begin
        res_pay_d  = pay_rd_ext[PORT_PAYLOAD_W-1:0];
        res_slot_d = pos_ext[PORT_SLOT_W-1:0];
      end
      RES_INS:       res_slot_d = pos_ext[PORT_SLOT_W-1:0];
      default:       res_status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= res_status_d;
      res_pay_q    <= res_pay_d;
      res_slot_q   <= res_slot_d;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_pay_q    <= res_pay_q;
      out_slot_q   <= res_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.in_clear    = (op_e'(op_i) == OP_CLEAR);
  assign sts_o.in_probe    = (op_e'(op_i) == OP_LOOKUP) || (op_e'(op_i) == OP_INSERT);
  assign sts_o.in_key_zero = (field_key_i == '0);
  assign sts_o.op_insert   = (op_e'(op_q) == OP_INSERT);
  assign sts_o.empty       = !rd_valid_q;
  assign sts_o.hit         = rd_valid_q && (rd_tag_q == tag_q) && (rd_key_q == key_q);
  assign sts_o.last_probe  = (i_q == '1);
  assign sts_o.sweep_last  = (pos_q == '1);
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign payload_out_o = out_pay_q;
  assign slot_index_o  = out_slot_q;

endmodule

FILE: rtl/qpht_ctrl.sv
`timescale 1ns / 1ps

module qpht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qpht_pkg::sts_t sts_i,
  output qpht_pkg::cmd_t cmd_o
);
  import qpht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT_CLR: if (sts_i.sweep_last) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_clear) begin
            state_d = S_OP_CLR;
          end else if (sts_i.in_probe && !sts_i.in_key_zero) begin
            state_d = S_PROBE_RD;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_OP_CLR:    if (sts_i.sweep_last) state_d = S_RESP;
      S_PROBE_RD:  state_d = S_PROBE_CMP;
      S_PROBE_CMP: begin
        if (sts_i.empty || sts_i.hit || sts_i.last_probe) begin
          state_d = S_RESP;
        end else begin
          state_d = S_PROBE_RD;
        end
      end
      S_RESP:      if (!sts_i.out_busy) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT_CLR: cmd_o.sweep = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = (sts_i.in_probe && sts_i.in_key_zero) ? RES_NULL : RES_OK;
        end
      end
      S_OP_CLR: begin
        cmd_o.sweep    = 1'b1;
        cmd_o.res_load = sts_i.sweep_last;
        cmd_o.res_sel  = RES_OK;
      end
      S_PROBE_RD: cmd_o = '0;
      S_PROBE_CMP: begin
        if (sts_i.empty || sts_i.hit) begin
          cmd_o.res_load = 1'b1;
          if (sts_i.op_insert) begin
            cmd_o.mem_write = 1'b1;
            cmd_o.res_sel   = RES_INS;
          end else begin
            cmd_o.res_sel = sts_i.hit ? RES_HIT : RES_NOT_FOUND;
          end
        end else if (sts_i.last_probe) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_FULL;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_RESP:  cmd_o.out_load = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
// Open-addressing hash table of 2**LOG2_SLOTS slots keyed by a class tag and a field key,
// probed from the home slot (low bits of the XOR of the keys) by triangular offsets. Each
// probe first reads the slot memory, then compares. A zero key on a lookup or insert, or
// the unused op code, goes straight to the result. A clear sweeps the valid store one slot
// a cycle. After reset the same sweep runs over every slot before the first input transfer
// is taken. The result sits in an output register, so the next input transfer is accepted
// while a finished result still waits to be taken.

`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table #(
  parameter int LOG2_SLOTS   = 10,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic signed [qpht_pkg::KEY_W-1:0]   class_tag_i,
  input  logic [qpht_pkg::KEY_W-1:0]          field_key_i,
  input  logic [qpht_pkg::PORT_PAYLOAD_W-1:0] payload_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [qpht_pkg::PORT_PAYLOAD_W-1:0] payload_out_o,
  output logic [qpht_pkg::PORT_SLOT_W-1:0]    slot_index_o
);
  import qpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences sweeps, probes and the result hand-off.
  qpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the slot memory, the probe counters and the result registers.
  qpht_datapath #(
    .LOG2_SLOTS   (LOG2_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .class_tag_i   (class_tag_i),
    .field_key_i   (field_key_i),
    .payload_in_i  (payload_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .payload_out_o (payload_out_o),
    .slot_index_o  (slot_index_o)
  );

  // Only one operation is in flight, so a transfer closes the input side.
  `QPHT_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second transfer taken")
  // A slot is only written once its probe found it empty or matching.
  `QPHT_ASSERT(a_write_on_hit_or_empty, cmd.mem_write |-> (sts.hit || sts.empty), "bad write")
  // A failed result carries neither a slot nor a payload.
  `QPHT_ASSERT(a_fail_zero_fields,
    (out_valid_o && status_o != ST_OK) |-> (slot_index_o == '0 && payload_out_o == '0),
    "failed result carries data")

endmodule

FILE: tb/quadratic_probe_hash_table_tb.sv
`timescale 1ns / 1ps

module quadratic_probe_hash_table_tb;
  import qpht_pkg::*;

  localparam int NUM_SLOTS    = 1024;
  localparam int SLOT_MASK    = NUM_SLOTS - 1;
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 810;
  localparam int POOL_SIZE    = 48;

  // Shadow copy of the table: it works out the answer for every accepted
  // request and keeps the answers in the order the block must return them.
  class hash_table_shadow;
    bit          used [NUM_SLOTS];
    bit [63:0]   tag_mem [NUM_SLOTS];
    bit [63:0]   key_mem [NUM_SLOTS];
    bit [31:0]   data_mem [NUM_SLOTS];
    status_e     want_status [$];
    bit [31:0]   want_data [$];
    bit [9:0]    want_slot [$];
    int          errors;

    function void wipe();
      foreach (used[s]) used[s] = 1'b0;
    endfunction

    // Walks the triangular probe chain: 0 match, 1 empty slot, 2 full.
    function int find_slot(bit [63:0] tag, bit [63:0] key, output int where);
      int pos;
      pos = int'((tag ^ key) & SLOT_MASK);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!used[pos]) begin
          where = pos;
          return 1;
        end
        if (tag_mem[pos] == tag && key_mem[pos] == key) begin
          where = pos;
          return 0;
        end
        pos = (pos + i + 1) & SLOT_MASK;
      end
      where = 0;
      return 2;
    endfunction

    function void note_request(op_e op, bit [63:0] tag, bit [63:0] key, bit [31:0] pay);
      status_e   st;
      bit [31:0] dout;
      bit [9:0]  sidx;
      int        where;
      int        r;
      st   = ST_OK;
      dout = '0;
      sidx = '0;
      if (op == OP_CLEAR) begin
        wipe();
      end else if (op == OP_LOOKUP || op == OP_INSERT) begin
        if (key == 0) begin
          st = ST_NULL_KEY;
        end else begin
          r = find_slot(tag, key, where);
          if (r == 2) begin
            st = ST_FULL;
          end else if (op == OP_LOOKUP) begin
            if (r == 0) begin
              dout = data_mem[where];
              sidx = where[9:0];
            end else begin
              st = ST_NOT_FOUND;
            end
          end else begin
            used[where]     = 1'b1;
            tag_mem[where]  = tag;
            key_mem[where]  = key;
            data_mem[where] = pay;
            sidx            = where[9:0];
          end
        end
      end
      want_status.push_back(st);
      want_data.push_back(dout);
      want_slot.push_back(sidx);
    endfunction

    function void check_response(logic [1:0] st, logic [31:0] dout, logic [9:0] sidx);
      status_e   e_st;
      bit [31:0] e_data;
      bit [9:0]  e_slot;
      if (want_status.size() == 0) begin
        $display("%0t: result with nothing outstanding: status %h data %h slot %h",
                 $time, st, dout, sidx);
        errors++;
        return;
      end
      e_st   = want_status.pop_front();
      e_data = want_data.pop_front();
      e_slot = want_slot.pop_front();
      if (st !== e_st) begin
        $display("%0t: status mismatch: expected %h actual %h", $time, e_st, st);
        errors++;
      end
      if (dout !== e_data) begin
        $display("%0t: payload mismatch: expected %h actual %h", $time, e_data, dout);
        errors++;
      end
      if (sidx !== e_slot) begin
        $display("%0t: slot mismatch: expected %h actual %h", $time, e_slot, sidx);
        errors++;
      end
    endfunction

    function int outstanding();
      return want_status.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [63:0] class_tag_i = '0;
  logic [63:0] field_key_i = '0;
  logic [31:0] payload_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] payload_out_o;
  logic [9:0]  slot_index_o;

  hash_table_shadow shadow = new();

  // When set, neither side inserts idle cycles, giving back-to-back stretches.
  bit          no_idle;
  int          stall_cnt = 0;
  int          quiet_cycles = 0;
  bit [63:0]   pool_tag [POOL_SIZE];
  bit [63:0]   pool_key [POOL_SIZE];

  always #10 clk_i = ~clk_i;

  quadratic_probe_hash_table u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .class_tag_i  (class_tag_i),
    .field_key_i  (field_key_i),
    .payload_in_i (payload_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .payload_out_o(payload_out_o),
    .slot_index_o (slot_index_o)
  );

  // Result side: every transfer is checked, then a fresh stall is drawn.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      shadow.check_response(status_o, payload_out_o, slot_index_o);
      stall_cnt = no_idle ? 0 : $urandom_range(0, 5);
    end
    if (stall_cnt > 0) begin
      out_ready_i <= 1'b0;
      stall_cnt--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: any stretch this long with no transfer on either side is a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is
  // only lowered when a gap follows, so a back-to-back request never sees a
  // low and a high assigned in the same time step.
  task automatic issue(op_e op, bit [63:0] tag, bit [63:0] key, bit [31:0] pay);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    class_tag_i  <= tag;
    field_key_i  <= key;
    payload_in_i <= pay;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.note_request(op, tag, key, pay);
  endtask

  // Holds the request side until every outstanding answer has been returned.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [31:0] rand_payload();
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    bit [63:0] tag;
    bit [63:0] key;
    int        pick;
    int        roll;

    no_idle      = 1'b0;
    shadow.wipe();

    // Key pool: the first sixteen entries all share one home slot, so inserts
    // of them walk a long triangular chain; the rest are scattered.
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_tag[i] = rand64();
      if (i < 16) begin
        pool_key[i] = pool_tag[i] ^ {54'(rand64() >> 10), 10'h155};
      end else begin
        pool_key[i] = rand64();
      end
      if (pool_key[i] == 0) pool_key[i] = 64'h1_0000_0000;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: null keys, a miss on an empty table, inserts at the
    // extremes of the key and payload ranges, an update, hits, the unused
    // op code and a clear followed by a miss.
    issue(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0, 32'hFFFF_FFFF);
    issue(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 32'h1234_5678);
    issue(OP_LOOKUP, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    issue(OP_INSERT, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1, 32'h0);
    issue(OP_INSERT, 64'h0, 64'h1, 32'hA5A5_5A5A);
    issue(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    issue(OP_INSERT, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0BAD_F00D);
    issue(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    issue(OP_LOOKUP, 64'h0, 64'h1, 32'hFFFF_FFFF);
    issue(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 32'h0);
    for (int i = 0; i < 6; i++) issue(OP_INSERT, pool_tag[i], pool_key[i], rand_payload());
    for (int i = 0; i < 7; i++) issue(OP_LOOKUP, pool_tag[i], pool_key[i], 32'h0);
    issue(OP_RSVD, rand64(), rand64(), $urandom);
    issue(OP_CLEAR, rand64(), 64'h0, $urandom);
    issue(OP_LOOKUP, pool_tag[0], pool_key[0], 32'h0);

    // The sender waits here for every outstanding answer before moving on.
    drain();

    // Random part: mostly inserts and lookups from the shared pool so that
    // hits, updates and collision chains are common, with fresh keys, null
    // keys, the unused op code and occasional clears mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, POOL_SIZE - 1);
      tag  = pool_tag[pick];
      key  = pool_key[pick];
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        tag = rand64();
        key = rand64();
      end else if (roll < 15) begin
        key = 64'h0;
        tag = rand64();
      end
      roll = $urandom_range(0, 99);
      if (roll < 48)      issue(OP_INSERT, tag, key, rand_payload());
      else if (roll < 94) issue(OP_LOOKUP, tag, key, rand_payload());
      else if (roll < 98) issue(OP_RSVD, tag, key, rand_payload());
      else                issue(OP_CLEAR, tag, key, rand_payload());
    end

    // Finally clear the table and confirm that a pool key is gone.
    no_idle = 1'b0;
    issue(OP_CLEAR, 64'h0, 64'h0, 32'h0);
    issue(OP_LOOKUP, pool_tag[1], pool_key[1], 32'h0);

    drain();
    repeat (50) @(posedge clk_i);

    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
